FILE: design/rlmc_pkg.sv
// shared types and codes for the radio link mode controller
package rlmc_pkg;

    // largest payload a send request may carry
    localparam logic [7:0] MAX_PAYLOAD = 8'd250;
    // header bytes added in front of the payload
    localparam logic [7:0] HDR_BYTES = 8'd6;
    // only a two-byte destination address is supported
    localparam logic [3:0] ADDR_LEN_SHORT = 4'd2;

    typedef enum logic [1:0] {
        EV_SLEEP  = 2'd0,
        EV_LISTEN = 2'd1,
        EV_SEND   = 2'd2,
        EV_EOP    = 2'd3
    } event_t;

    // externally visible radio state code
    typedef enum logic [1:0] {
        RS_OFF  = 2'd0,
        RS_IDLE = 2'd1,
        RS_RX   = 2'd2,
        RS_TX   = 2'd3
    } radio_code_t;

    // internal mode state, one-hot
    typedef enum logic [3:0] {
        ST_OFF  = 4'b0001,
        ST_IDLE = 4'b0010,
        ST_RX   = 4'b0100,
        ST_TX   = 4'b1000
    } mode_state_t;

    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_TOO_LARGE = 2'd1,
        ERR_ADDR_LEN  = 2'd2,
        ERR_BUSY      = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        BUF_RX0 = 2'd0,
        BUF_RX1 = 2'd1,
        BUF_TX  = 2'd2
    } buf_sel_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] dest_address;
        logic [3:0]  dest_address_length;
        logic [7:0]  payload_length;
        logic [1:0]  payload_kind;
        logic        crc_good;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  radio_state;
        logic [1:0]  error_code;
        logic        frame_received;
        logic        received_buffer;
        logic [1:0]  packet_buffer;
        logic [15:0] match_address;
        logic        radio_start;
        logic [7:0]  frame_length;
        logic [15:0] frame_source;
        logic [2:0]  frame_protocol;
    } out_item_t;

endpackage

FILE: design/radio_link_mode_controller.sv
// radio link mode controller: registered event decision with result register
// an input transaction passes the input register, then the result register
// throughput: one event per cycle unless stalled; decision is one registered pass
// a stalled result register holds the input register, which takes one item if empty
// reset: synchronous active-low aresetn; mode off, pre-send mode off, buffer
// select 0, radio pointer rx0, address match 0, own_address 0, both stages empty
module radio_link_mode_controller
    import rlmc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // configuration write channel (own_address)
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,

    // event input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,

    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    // configuration register
    logic [15:0] own_address_reg;

    // input stage
    logic        in_valid_reg;
    in_item_t    in_item_reg;

    // controller state carried between events
    mode_state_t mode_reg, mode_next;
    mode_state_t prior_mode_reg, prior_mode_next;
    logic        free_sel_reg, free_sel_next;
    logic [1:0]  pointer_reg, pointer_next;
    logic [15:0] match_reg, match_next;

    // result stage
    logic        out_valid_reg;
    out_item_t   out_item_reg, out_item_next;

    // decision stage moves when it holds an event and the result slot is free
    logic        advance;
    event_t      ev;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_item_reg;
    assign ev        = event_t'(in_item_reg.mode);

    // one-hot mode to the two-bit code the radio state output carries
    function automatic logic [1:0] state_code(input mode_state_t st);
        logic [1:0] code;
        unique case (st)
            ST_OFF:  code = RS_OFF;
            ST_IDLE: code = RS_IDLE;
            ST_RX:   code = RS_RX;
            ST_TX:   code = RS_TX;
            default: code = RS_OFF;
        endcase
        return code;
    endfunction

    // event decision
    always_comb begin
        mode_next       = mode_reg;
        prior_mode_next = prior_mode_reg;
        free_sel_next   = free_sel_reg;
        pointer_next    = pointer_reg;
        match_next      = match_reg;

        out_item_next                 = '0;
        out_item_next.error_code      = ERR_OK;

        unique case (ev)
            EV_SLEEP: begin
                // also abandons any transmission in progress
                mode_next = ST_IDLE;
            end
            EV_LISTEN: begin
                pointer_next               = {1'b0, free_sel_reg};
                match_next                 = own_address_reg;
                mode_next                  = ST_RX;
                out_item_next.radio_start  = 1'b1;
            end
            EV_SEND: begin
                // checks in priority order: size, address length, busy
                priority if (in_item_reg.payload_length > MAX_PAYLOAD) begin
                    out_item_next.error_code = ERR_TOO_LARGE;
                end else if (in_item_reg.dest_address_length != ADDR_LEN_SHORT) begin
                    out_item_next.error_code = ERR_ADDR_LEN;
                end else if (mode_reg == ST_TX) begin
                    out_item_next.error_code = ERR_BUSY;
                end else begin
                    // length byte wraps for the largest payload
                    out_item_next.frame_length   = HDR_BYTES + in_item_reg.payload_length;
                    out_item_next.frame_source   = own_address_reg;
                    out_item_next.frame_protocol = {1'b0, in_item_reg.payload_kind} + 3'd1;
                    out_item_next.radio_start    = 1'b1;
                    prior_mode_next              = mode_reg;
                    pointer_next                 = BUF_TX;
                    match_next                   = in_item_reg.dest_address;
                    mode_next                    = ST_TX;
                end
            end
            EV_EOP: begin
                if (mode_reg == ST_RX) begin
                    // bad crc drops the frame and leaves everything as is
                    if (in_item_reg.crc_good) begin
                        out_item_next.frame_received  = 1'b1;
                        out_item_next.received_buffer = free_sel_reg;
                        out_item_next.radio_start     = 1'b1;
                        free_sel_next                 = ~free_sel_reg;
                        pointer_next                  = {1'b0, ~free_sel_reg};
                    end
                end else if (mode_reg == ST_TX) begin
                    mode_next = ST_IDLE;
                    // go back to listening if that is where the send started
                    if (prior_mode_reg == ST_RX) begin
                        pointer_next              = {1'b0, free_sel_reg};
                        match_next                = own_address_reg;
                        mode_next                 = ST_RX;
                        out_item_next.radio_start = 1'b1;
                    end
                end
                // end-of-packet while off or idle is ignored
            end
            default: begin
                mode_next = mode_reg;
            end
        endcase

        out_item_next.radio_state   = state_code(mode_next);
        out_item_next.packet_buffer = pointer_next;
        out_item_next.match_address = match_next;
    end

    // configuration register: write only with no transaction in flight (not enforced)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_address_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            own_address_reg <= cfg_data;
        end
    end

    // input stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // input stage payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    // controller state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= ST_OFF;
            prior_mode_reg <= ST_OFF;
            free_sel_reg   <= 1'b0;
            pointer_reg    <= BUF_RX0;
            match_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (advance) begin
                mode_reg       <= mode_next;
                prior_mode_reg <= prior_mode_next;
                free_sel_reg   <= free_sel_next;
                pointer_reg    <= pointer_next;
                match_reg      <= match_next;
                out_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the radio link mode controller with its own mode predictor
module tb_top;
    import rlmc_pkg::*;

    // generous run limit: 625 events under heavy idling plus the long hold-off
    localparam int LIMIT_CYCLES  = 200000;
    // cycles to let pass once nothing is outstanding (two-stage pipeline plus margin)
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_EVENTS  = 150;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_item_t   m_data;

    // stimulus and expectation stores
    in_item_t    event_fifo[$];
    out_item_t   status_fifo[$];
    bit          event_taken;

    // idling knobs, set between phases; rx_hold follows the long hold-off
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_req = 1'b0;
    bit          rx_hold  = 1'b0;

    // predictor state, mirrors the block after reset
    radio_code_t cur_state     = RS_OFF;
    radio_code_t pre_send_state = RS_OFF;
    logic        rx_sel        = 1'b0;
    buf_sel_t    buf_ptr       = BUF_RX0;
    logic [15:0] match_addr    = '0;
    logic [15:0] own_addr_cfg  = '0;

    // run statistics
    int unsigned fail_count   = 0;
    int unsigned events_sent  = 0;
    int unsigned results_seen = 0;
    int unsigned sends_ok     = 0;
    int unsigned sends_bad    = 0;
    int unsigned frames_got   = 0;
    int unsigned cfg_writes   = 0;
    int unsigned cycle_count  = 0;

    radio_link_mode_controller u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // radio goes to receive: point at the free rx buffer and match our own address
    function automatic void enter_rx();
        buf_ptr    = buf_sel_t'({1'b0, rx_sel});
        match_addr = own_addr_cfg;
        cur_state  = RS_RX;
    endfunction

    // advance the predicted controller by one event and return the status it must report
    function automatic out_item_t advance_radio(in_item_t ev);
        out_item_t r;
        r = '0;
        case (ev.mode)
            EV_SLEEP: begin
                // also abandons a transmission in flight
                cur_state = RS_IDLE;
            end
            EV_LISTEN: begin
                enter_rx();
                r.radio_start = 1'b1;
            end
            EV_SEND: begin
                // check order: payload size, then address length, then busy
                if (ev.payload_length > MAX_PAYLOAD) begin
                    r.error_code = ERR_TOO_LARGE;
                end else if (ev.dest_address_length != ADDR_LEN_SHORT) begin
                    r.error_code = ERR_ADDR_LEN;
                end else if (cur_state == RS_TX) begin
                    r.error_code = ERR_BUSY;
                end else begin
                    // length byte wraps for the largest payload
                    r.frame_length   = HDR_BYTES + ev.payload_length;
                    r.frame_source   = own_addr_cfg;
                    r.frame_protocol = {1'b0, ev.payload_kind} + 3'd1;
                    pre_send_state   = cur_state;
                    buf_ptr          = BUF_TX;
                    match_addr       = ev.dest_address;
                    cur_state        = RS_TX;
                    r.radio_start    = 1'b1;
                end
                if (r.error_code == ERR_OK) sends_ok++;
                else sends_bad++;
            end
            default: begin
                // end of packet: ignored when off or idle
                if (cur_state == RS_RX) begin
                    if (ev.crc_good) begin
                        r.frame_received  = 1'b1;
                        r.received_buffer = rx_sel;
                        rx_sel            = ~rx_sel;
                        buf_ptr           = buf_sel_t'({1'b0, rx_sel});
                        r.radio_start     = 1'b1;
                        frames_got++;
                    end
                end else if (cur_state == RS_TX) begin
                    cur_state = RS_IDLE;
                    if (pre_send_state == RS_RX) begin
                        enter_rx();
                        r.radio_start = 1'b1;
                    end
                end
            end
        endcase
        r.radio_state   = cur_state;
        r.packet_buffer = buf_ptr;
        r.match_address = match_addr;
        return r;
    endfunction

    function automatic in_item_t make_event(logic [1:0] mode, logic [15:0] dest,
                                            logic [3:0] dlen, logic [7:0] plen,
                                            logic [1:0] kind, logic crc);
        in_item_t it;
        it.mode                = mode;
        it.dest_address        = dest;
        it.dest_address_length = dlen;
        it.payload_length      = plen;
        it.payload_kind        = kind;
        it.crc_good            = crc;
        return it;
    endfunction

    // random events of every kind; most sends are well-formed with random content, the rest may be malformed
    function automatic in_item_t rand_radio_event();
        in_item_t it;
        int unsigned pick;
        it.dest_address        = 16'($urandom);
        it.dest_address_length = 4'($urandom);
        it.payload_length      = 8'($urandom);
        it.payload_kind        = 2'($urandom);
        it.crc_good            = ($urandom_range(99) < 75);
        pick = $urandom_range(99);
        if (pick < 15)      it.mode = EV_SLEEP;
        else if (pick < 35) it.mode = EV_LISTEN;
        else if (pick < 70) it.mode = EV_SEND;
        else                it.mode = EV_EOP;
        if (it.mode == EV_SEND && $urandom_range(99) < 80) begin
            it.dest_address_length = ADDR_LEN_SHORT;
            if (it.payload_length > MAX_PAYLOAD) it.payload_length = 8'($urandom_range(250));
        end
        return it;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // event input: accept at the rising edge and predict right away
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            status_fifo.push_back(advance_radio(s_data));
            event_taken = 1'b1;
            events_sent++;
        end
    end

    // event driver: load the next transaction on the falling edge, with random gaps
    always @(negedge aclk) begin
        if (!s_valid || event_taken) begin
            event_taken = 1'b0;
            if (event_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= event_fifo.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure, forced low during the long hold-off
    always @(negedge aclk) begin
        m_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // long receiver hold-off, counted here so the sender keeps pushing into a full block
    initial begin
        wait (hold_req);
        @(posedge aclk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold = 1'b0;
    end

    // result monitor: compare each transaction with the oldest expectation
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (status_fifo.size() == 0) begin
                $error("result transaction with no event outstanding");
                fail_count++;
            end else begin
                want = status_fifo.pop_front();
                check_field("radio_state", 16'(want.radio_state),
                            16'(m_data.radio_state));
                check_field("error_code", 16'(want.error_code),
                            16'(m_data.error_code));
                check_field("frame_received", 16'(want.frame_received),
                            16'(m_data.frame_received));
                check_field("received_buffer", 16'(want.received_buffer),
                            16'(m_data.received_buffer));
                check_field("packet_buffer", 16'(want.packet_buffer),
                            16'(m_data.packet_buffer));
                check_field("match_address", want.match_address, m_data.match_address);
                check_field("radio_start", 16'(want.radio_start),
                            16'(m_data.radio_start));
                check_field("frame_length", 16'(want.frame_length),
                            16'(m_data.frame_length));
                check_field("frame_source", want.frame_source, m_data.frame_source);
                check_field("frame_protocol", 16'(want.frame_protocol),
                            16'(m_data.frame_protocol));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // wait until every queued event went in and every status came back
    task automatic drain();
        while (event_fifo.size() != 0 || s_valid || status_fifo.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // own_address write, only while the block is idle
    task automatic write_own_address(input logic [15:0] addr);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= addr;
        do @(posedge aclk); while (!cfg_ready);
        own_addr_cfg = addr;
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input logic [15:0] addr, input int unsigned idle_pct,
                                input int unsigned stall_pct, input bit with_hold);
        write_own_address(addr);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (PHASE_EVENTS) event_fifo.push_back(rand_radio_event());
        if (with_hold) hold_req = 1'b1;
        drain();
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(posedge aclk);

        // directed walk through the states with own_address at its reset value
        event_fifo.push_back(make_event(EV_EOP,    16'h1234, 4'd2,  8'd10,  2'd0, 1'b1)); // eop while off
        event_fifo.push_back(make_event(EV_SEND,   16'hffff, 4'd2,  8'd0,   2'd0, 1'b0)); // send from off
        event_fifo.push_back(make_event(EV_EOP,    16'h0000, 4'd0,  8'd0,   2'd0, 1'b0)); // tx done, to idle
        event_fifo.push_back(make_event(EV_EOP,    16'h0000, 4'd0,  8'd0,   2'd0, 1'b1)); // eop while idle
        event_fifo.push_back(make_event(EV_LISTEN, 16'hffff, 4'hf,  8'hff,  2'd3, 1'b1));
        event_fifo.push_back(make_event(EV_EOP,    16'h0000, 4'd2,  8'd0,   2'd0, 1'b0)); // bad crc
        event_fifo.push_back(make_event(EV_EOP,    16'h0000, 4'd2,  8'd0,   2'd0, 1'b1)); // good crc
        event_fifo.push_back(make_event(EV_EOP,    16'hffff, 4'd2,  8'd0,   2'd0, 1'b1)); // flips back
        event_fifo.push_back(make_event(EV_SEND,   16'h00ff, 4'd2,  8'd251, 2'd1, 1'b0)); // too large
        event_fifo.push_back(make_event(EV_SEND,   16'h00ff, 4'd0,  8'd255, 2'd1, 1'b0)); // size before len
        event_fifo.push_back(make_event(EV_SEND,   16'h00ff, 4'd0,  8'd5,   2'd2, 1'b0)); // bad length
        event_fifo.push_back(make_event(EV_SEND,   16'h00ff, 4'd8,  8'd5,   2'd2, 1'b0));
        event_fifo.push_back(make_event(EV_SEND,   16'h00ff, 4'hf,  8'd5,   2'd2, 1'b0));
        event_fifo.push_back(make_event(EV_SEND,   16'hffff, 4'd2,  8'd250, 2'd3, 1'b1)); // length wraps
        event_fifo.push_back(make_event(EV_SEND,   16'h0001, 4'd2,  8'd1,   2'd0, 1'b0)); // busy
        event_fifo.push_back(make_event(EV_SEND,   16'h0001, 4'd2,  8'd251, 2'd0, 1'b0)); // size wins
        event_fifo.push_back(make_event(EV_SEND,   16'h0001, 4'd3,  8'd1,   2'd0, 1'b0)); // length wins
        event_fifo.push_back(make_event(EV_EOP,    16'h0000, 4'd2,  8'd0,   2'd0, 1'b0)); // back to rx
        event_fifo.push_back(make_event(EV_SEND,   16'h0000, 4'd2,  8'd0,   2'd3, 1'b0));
        event_fifo.push_back(make_event(EV_SLEEP,  16'hffff, 4'hf,  8'hff,  2'd3, 1'b1)); // abandon tx
        event_fifo.push_back(make_event(EV_SEND,   16'h8000, 4'd2,  8'd249, 2'd1, 1'b1)); // from idle
        event_fifo.push_back(make_event(EV_LISTEN, 16'h0000, 4'd0,  8'd0,   2'd0, 1'b0)); // abandon tx
        event_fifo.push_back(make_event(EV_SLEEP,  16'h0000, 4'd0,  8'd0,   2'd0, 1'b0));
        event_fifo.push_back(make_event(EV_SLEEP,  16'h0000, 4'd0,  8'd0,   2'd0, 1'b0));
        event_fifo.push_back(make_event(EV_EOP,    16'h0000, 4'd0,  8'd0,   2'd0, 1'b1)); // idle again
        drain();

        // random phases across own_address settings and idling mixes
        random_phase(16'hffff, 0, 0, 1'b1);      // no idling, with the long hold-off
        random_phase(16'h0000, 58, 0, 1'b0);     // sender idles
        random_phase(16'($urandom), 0, 58, 1'b0); // receiver stalls
        random_phase(16'h8001, 32, 32, 1'b0);    // both sides idle

        drain();
        $display("covered %0d events and %0d results over %0d own_address writes",
                 events_sent, results_seen, cfg_writes);
        $display("sends started %0d, sends rejected %0d, good frames received %0d",
                 sends_ok, sends_bad, frames_got);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
